>>> rtl/core/abe_pkg.sv
// ----------------------------------------------------------------------------
// Allocation bitmap engine package
// Shared widths, operation codes, status codes and the control structures
// passed between the sequencer and the byte evaluation unit.
// ----------------------------------------------------------------------------
package abe_pkg;

  localparam int MODE_W    = 3;
  localparam int OFFSET_W  = 12;
  localparam int LEN_W     = 13;
  localparam int FOFF_W    = 13;
  localparam int STATUS_W  = 2;
  localparam int SEARCH_W  = 10;
  localparam int WORD_W    = 8;
  localparam int BIT_IDX_W = 3;
  // Byte index of the last bit of a run: (offset + length - 1) / 8 needs 11 bits.
  localparam int BYTE_W    = 11;
  localparam int UOP_W     = 3;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [OFFSET_W-1:0]  offset_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [FOFF_W-1:0]    foff_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [SEARCH_W-1:0]  search_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [BIT_IDX_W-1:0] bit_idx_t;
  typedef logic [BYTE_W-1:0]    byte_idx_t;
  typedef logic [UOP_W-1:0]     uop_t;

  // Request modes.
  localparam mode_t MODE_SET   = 3'd0;
  localparam mode_t MODE_CLR   = 3'd1;
  localparam mode_t MODE_INV   = 3'd2;
  localparam mode_t MODE_READ  = 3'd3;
  localparam mode_t MODE_WRITE = 3'd4;
  localparam mode_t MODE_FIND  = 3'd5;

  // Result status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_RANGE     = 2'd2;

  // Operations of the byte evaluation unit.
  localparam uop_t UOP_SET  = 3'd0;
  localparam uop_t UOP_CLR  = 3'd1;
  localparam uop_t UOP_INV  = 3'd2;
  localparam uop_t UOP_READ = 3'd3;
  localparam uop_t UOP_FIND = 3'd4;

  localparam search_t SEARCH_RESET = 10'd512;

  typedef struct packed {
    uop_t     op;
    bit_idx_t lo;
    bit_idx_t hi;
    logic     val;
    len_t     run_in;
    len_t     len;
  } unit_ctrl_t;

  typedef struct packed {
    word_t    wr_byte;
    logic     hit;
    bit_idx_t hit_pos;
    len_t     run_out;
  } unit_res_t;

endpackage

>>> rtl/core/abe_chan_if.sv
// ----------------------------------------------------------------------------
// Allocation bitmap engine channels
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface abe_in_if;
  logic              valid;
  logic              ready;
  abe_pkg::mode_t    mode;
  abe_pkg::offset_t  bit_offset;
  abe_pkg::len_t     run_length;
  logic              bit_value;

  modport source (output valid, output mode, output bit_offset, output run_length,
                  output bit_value, input ready);
  modport sink (input valid, input mode, input bit_offset, input run_length,
                input bit_value, output ready);
endinterface

interface abe_out_if;
  logic              valid;
  logic              ready;
  logic              read_bit;
  abe_pkg::foff_t    found_offset;
  abe_pkg::status_t  status;

  modport source (output valid, output read_bit, output found_offset, output status,
                  input ready);
  modport sink (input valid, input read_bit, input found_offset, input status,
                output ready);
endinterface

>>> rtl/core/abe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module abe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/abe_byte_unit.sv
// ----------------------------------------------------------------------------
// Byte evaluation unit
// Applies a masked set/clear/invert to one bitmap byte, and advances the
// run counter of a find over the eight bits of one byte.
// ----------------------------------------------------------------------------
module abe_byte_unit (
  input  abe_pkg::unit_ctrl_t ctrl_i,
  input  abe_pkg::word_t      data_i,
  output abe_pkg::unit_res_t  res_o
);

  logic [abe_pkg::WORD_W-1:0]    mask;
  logic [abe_pkg::WORD_W-1:0]    match;
  logic [abe_pkg::WORD_W-1:0]    prefix;
  logic [abe_pkg::WORD_W-1:0]    hits;
  logic [3:0]                    streak [abe_pkg::WORD_W];
  abe_pkg::len_t                 run_at [abe_pkg::WORD_W];

  always_comb begin
    for (int j = 0; j < abe_pkg::WORD_W; j++) begin
      mask[j] = (abe_pkg::BIT_IDX_W'(j) >= ctrl_i.lo) && (abe_pkg::BIT_IDX_W'(j) <= ctrl_i.hi);
    end

    case (ctrl_i.op)
      abe_pkg::UOP_SET: res_o.wr_byte = data_i | mask;
      abe_pkg::UOP_CLR: res_o.wr_byte = data_i & ~mask;
      abe_pkg::UOP_INV: res_o.wr_byte = data_i ^ mask;
      default:          res_o.wr_byte = data_i;
    endcase

    // Bits equal to the searched value, with the streak ending at each bit.
    match     = ctrl_i.val ? data_i : ~data_i;
    prefix[0] = match[0];
    streak[0] = {3'b000, match[0]};
    for (int j = 1; j < abe_pkg::WORD_W; j++) begin
      prefix[j] = match[j] & prefix[j-1];
      streak[j] = match[j] ? (streak[j-1] + 4'd1) : 4'd0;
    end

    // A streak reaching back to bit 0 continues the run carried in.
    for (int j = 0; j < abe_pkg::WORD_W; j++) begin
      run_at[j] = prefix[j] ? (ctrl_i.run_in + abe_pkg::LEN_W'(j + 1))
                            : abe_pkg::LEN_W'(streak[j]);
      hits[j]   = match[j] && (run_at[j] == ctrl_i.len);
    end

    res_o.hit     = |hits;
    res_o.hit_pos = '0;
    for (int j = abe_pkg::WORD_W - 1; j >= 0; j--) begin
      if (hits[j]) begin
        res_o.hit_pos = abe_pkg::BIT_IDX_W'(j);
      end
    end

    res_o.run_out = prefix[abe_pkg::WORD_W-1] ? run_at[abe_pkg::WORD_W-1]
                                             : abe_pkg::LEN_W'(streak[abe_pkg::WORD_W-1]);
  end

endmodule

>>> rtl/core/allocation_bitmap_engine_core.sv
// ----------------------------------------------------------------------------
// Allocation bitmap engine
// Bitmap of BITMAP_BYTES bytes with run set/clear/invert, single-bit read and
// write, and a first-fit search for a run of equal bits.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (mode, bit_offset, run_length, bit_value)
// and each produces exactly one result transaction on out_ch (read_bit,
// found_offset, status). The user must write the search limit register via
// cfg_wr_en/cfg_wr_data only while the engine is idle; nothing enforces it.
// Throughput: one request is handled at a time, and in_ch.ready is high
// only while the sequencer is idle. The bitmap RAM is walked one byte per
// cycle through a single read port and a shared byte evaluation unit; each
// byte is read, then evaluated and, for a run or a write, written back. A
// find stops at its first matching run or at the end of the scan limit.
// Requests rejected by range or length checks, and unused modes, skip the
// RAM walk.
// Reset: after rst_n is released, a clearing pass writes zero to every bitmap
// byte, one byte per cycle, for BITMAP_BYTES cycles; no request is accepted
// during the pass. The search limit resets to 512 bytes.
// Stall: a finished result sits in the output register while the receiver
// holds out_ch.ready low; the next request may still be accepted and is
// worked on, and its result waits until the output register is free.
// ----------------------------------------------------------------------------
module allocation_bitmap_engine_core #(
  parameter int BITMAP_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  abe_pkg::search_t   cfg_wr_data,
  abe_in_if.sink             in_ch,
  abe_out_if.source          out_ch
);

  localparam int AW         = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int TOTAL_BITS = BITMAP_BYTES * abe_pkg::WORD_W;
  localparam int CW         = ($clog2(TOTAL_BITS + 1) > 14) ? $clog2(TOTAL_BITS + 1) : 14;
  // A find never scans more than the bitmap or the largest register value.
  localparam int SAT_BYTES  = (BITMAP_BYTES < 1023) ? BITMAP_BYTES : 1023;

  localparam logic [CW-1:0]                TOTAL_C   = CW'(TOTAL_BITS);
  localparam abe_pkg::search_t             SAT_C     = abe_pkg::SEARCH_W'(SAT_BYTES);
  localparam logic [AW-1:0]                LAST_ADDR = AW'(BITMAP_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  abe_pkg::search_t       search_bytes_r, search_bytes_nxt;
  abe_pkg::uop_t          op_r, op_nxt;
  abe_pkg::bit_idx_t      lo_r, lo_nxt;
  abe_pkg::bit_idx_t      hi_r, hi_nxt;
  abe_pkg::byte_idx_t     first_r, first_nxt;
  abe_pkg::byte_idx_t     last_r, last_nxt;
  abe_pkg::byte_idx_t     cur_r, cur_nxt;
  abe_pkg::byte_idx_t     p_byte_r, p_byte_nxt;
  logic                   issuing_r, issuing_nxt;
  logic                   pend_r, pend_nxt;
  abe_pkg::len_t          run_r, run_nxt;
  abe_pkg::len_t          len_r, len_nxt;
  logic                   val_r, val_nxt;
  logic                   res_rbit_r, res_rbit_nxt;
  abe_pkg::foff_t         res_foff_r, res_foff_nxt;
  abe_pkg::status_t       res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_rbit_r, out_rbit_nxt;
  abe_pkg::foff_t         out_foff_r, out_foff_nxt;
  abe_pkg::status_t       out_status_r, out_status_nxt;

  logic [13:0]            run_sum;
  logic [13:0]            run_end;
  logic                   run_range_err;
  logic                   bit_range_err;
  abe_pkg::search_t       scan_bytes;
  abe_pkg::foff_t         scan_limit;
  abe_pkg::foff_t         hit_foff;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  abe_pkg::word_t         ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  abe_pkg::word_t         ram_rdata;

  abe_pkg::unit_ctrl_t    unit_ctrl;
  abe_pkg::unit_res_t     unit_res;

  abe_ram #(
    .WIDTH (abe_pkg::WORD_W),
    .DEPTH (BITMAP_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  abe_byte_unit u_unit (
    .ctrl_i (unit_ctrl),
    .data_i (ram_rdata),
    .res_o  (unit_res)
  );

  // Range checks and the search limit of the request at the input.
  assign run_sum       = {2'b00, in_ch.bit_offset} + {1'b0, in_ch.run_length};
  assign run_end       = run_sum - 14'd1;
  assign run_range_err = CW'(run_sum) > TOTAL_C;
  assign bit_range_err = CW'(in_ch.bit_offset) >= TOTAL_C;
  assign scan_bytes    = (search_bytes_r > SAT_C) ? SAT_C : search_bytes_r;
  assign scan_limit    = {scan_bytes, 3'b000};

  // The byte in flight is masked only at the ends of the run.
  always_comb begin
    unit_ctrl.op     = op_r;
    unit_ctrl.lo     = (p_byte_r == first_r) ? lo_r : 3'd0;
    unit_ctrl.hi     = (p_byte_r == last_r) ? hi_r : 3'd7;
    unit_ctrl.val    = val_r;
    unit_ctrl.run_in = run_r;
    unit_ctrl.len    = len_r;
  end

  // Start of the found run: bit index of its last bit, plus one, minus length.
  assign hit_foff = abe_pkg::FOFF_W'({p_byte_r, unit_res.hit_pos}) + 13'd1 - len_r;

  always_comb begin
    state_nxt        = state_r;
    clr_addr_nxt     = clr_addr_r;
    search_bytes_nxt = search_bytes_r;
    op_nxt           = op_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    first_nxt        = first_r;
    last_nxt         = last_r;
    cur_nxt          = cur_r;
    p_byte_nxt       = p_byte_r;
    issuing_nxt      = issuing_r;
    pend_nxt         = pend_r;
    run_nxt          = run_r;
    len_nxt          = len_r;
    val_nxt          = val_r;
    res_rbit_nxt     = res_rbit_r;
    res_foff_nxt     = res_foff_r;
    res_status_nxt   = res_status_r;
    out_valid_nxt    = out_valid_r;
    out_rbit_nxt     = out_rbit_r;
    out_foff_nxt     = out_foff_r;
    out_status_nxt   = out_status_r;

    ram_we    = 1'b0;
    ram_waddr = AW'(p_byte_r);
    ram_wdata = unit_res.wr_byte;
    ram_re    = 1'b0;
    ram_raddr = AW'(cur_r);

    if (cfg_wr_en) begin
      search_bytes_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt      = S_DONE;
          res_rbit_nxt   = 1'b0;
          res_foff_nxt   = '0;
          res_status_nxt = abe_pkg::ST_OK;
          issuing_nxt    = 1'b1;
          pend_nxt       = 1'b0;
          run_nxt        = '0;
          len_nxt        = in_ch.run_length;
          val_nxt        = in_ch.bit_value;
          first_nxt      = abe_pkg::BYTE_W'(in_ch.bit_offset[11:3]);
          last_nxt       = abe_pkg::BYTE_W'(in_ch.bit_offset[11:3]);
          cur_nxt        = abe_pkg::BYTE_W'(in_ch.bit_offset[11:3]);
          lo_nxt         = in_ch.bit_offset[2:0];
          hi_nxt         = in_ch.bit_offset[2:0];
          unique case (in_ch.mode) inside
            abe_pkg::MODE_SET, abe_pkg::MODE_CLR, abe_pkg::MODE_INV: begin
              if (in_ch.run_length != '0) begin
                if (run_range_err) begin
                  res_status_nxt = abe_pkg::ST_RANGE;
                end else begin
                  state_nxt = S_RUN;
                  op_nxt    = (in_ch.mode == abe_pkg::MODE_SET) ? abe_pkg::UOP_SET :
                              (in_ch.mode == abe_pkg::MODE_CLR) ? abe_pkg::UOP_CLR :
                                                                  abe_pkg::UOP_INV;
                  last_nxt  = run_end[13:3];
                  hi_nxt    = run_end[2:0];
                end
              end
            end
            abe_pkg::MODE_READ: begin
              if (bit_range_err) begin
                res_status_nxt = abe_pkg::ST_RANGE;
              end else begin
                state_nxt = S_RUN;
                op_nxt    = abe_pkg::UOP_READ;
              end
            end
            abe_pkg::MODE_WRITE: begin
              res_foff_nxt = abe_pkg::FOFF_W'(in_ch.bit_offset);
              if (bit_range_err) begin
                res_status_nxt = abe_pkg::ST_RANGE;
              end else begin
                state_nxt = S_RUN;
                op_nxt    = in_ch.bit_value ? abe_pkg::UOP_SET : abe_pkg::UOP_CLR;
              end
            end
            abe_pkg::MODE_FIND: begin
              res_foff_nxt   = scan_limit;
              res_status_nxt = abe_pkg::ST_NOT_FOUND;
              // Zero length, empty scan or a run longer than the scan cannot match.
              if ((in_ch.run_length != '0) && (scan_bytes != '0) &&
                  (in_ch.run_length <= scan_limit)) begin
                state_nxt = S_FIND;
                op_nxt    = abe_pkg::UOP_FIND;
                first_nxt = '0;
                cur_nxt   = '0;
                last_nxt  = abe_pkg::BYTE_W'(scan_bytes - 10'd1);
                lo_nxt    = 3'd0;
                hi_nxt    = 3'd7;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN, S_FIND: begin
        // Issue one byte read per cycle; its data is evaluated in the next cycle.
        if (issuing_r) begin
          ram_re     = 1'b1;
          p_byte_nxt = cur_r;
          pend_nxt   = 1'b1;
          cur_nxt    = cur_r + abe_pkg::BYTE_W'(1);
          if (cur_r == last_r) begin
            issuing_nxt = 1'b0;
          end
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          if (state_r == S_RUN) begin
            if (op_r == abe_pkg::UOP_READ) begin
              res_rbit_nxt = ram_rdata[lo_r];
            end else begin
              ram_we = 1'b1;
            end
            if (!issuing_r) begin
              state_nxt = S_DONE;
            end
          end else begin
            run_nxt = unit_res.run_out;
            if (unit_res.hit) begin
              res_foff_nxt   = hit_foff;
              res_status_nxt = abe_pkg::ST_OK;
              state_nxt      = S_DONE;
              issuing_nxt    = 1'b0;
              pend_nxt       = 1'b0;
            end else if (!issuing_r) begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_rbit_nxt   = res_rbit_r;
          out_foff_nxt   = res_foff_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_addr_r     <= '0;
      search_bytes_r <= abe_pkg::SEARCH_RESET;
      issuing_r      <= 1'b0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      search_bytes_r <= search_bytes_nxt;
      issuing_r      <= issuing_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    cur_r        <= cur_nxt;
    p_byte_r     <= p_byte_nxt;
    run_r        <= run_nxt;
    len_r        <= len_nxt;
    val_r        <= val_nxt;
    res_rbit_r   <= res_rbit_nxt;
    res_foff_r   <= res_foff_nxt;
    res_status_r <= res_status_nxt;
    out_rbit_r   <= out_rbit_nxt;
    out_foff_r   <= out_foff_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_bit     = out_rbit_r;
  assign out_ch.found_offset = out_foff_r;
  assign out_ch.status       = out_status_r;

endmodule

>>> test/tb_allocation_bitmap_engine_core.sv
// ----------------------------------------------------------------------------
// Allocation bitmap engine core testbench
// Drives set/clear/invert runs, single-bit reads and writes and first-fit
// searches through the request channel, predicts every result with an
// in-bench copy of the bitmap and the search limit, and compares each result
// transaction field by field. Directed corner cases come first, then random
// phases under several search limits with random idling on both channels and
// two long receiver stalls that back the engine up into its input.
// ----------------------------------------------------------------------------
module tb_allocation_bitmap_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BITMAP_BYTES = 512;
  localparam int unsigned TOTAL_BITS = BITMAP_BYTES * 8;

  // Modes 6 and 7 have no meaning; the engine must answer them with zeros.
  localparam abe_pkg::mode_t MODE_SPARE_LO = 3'd6;
  localparam abe_pkg::mode_t MODE_SPARE_HI = 3'd7;

  // A quiet stretch longer than any find over the whole bitmap or any long
  // receiver stall means a hang.
  localparam int STUCK_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SQUEEZE_FIRST  = 100;
  localparam int SQUEEZE_SECOND = 520;
  localparam int DRAIN_CYCLES   = 32;

  typedef struct packed {
    abe_pkg::mode_t   mode;
    abe_pkg::offset_t bit_offset;
    abe_pkg::len_t    run_length;
    logic             bit_value;
  } request_t;

  typedef struct packed {
    logic             read_bit;
    abe_pkg::foff_t   found_offset;
    abe_pkg::status_t status;
  } result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  abe_pkg::search_t cfg_wr_data;

  abe_in_if  in_bus ();
  abe_out_if out_bus ();

  allocation_bitmap_engine_core #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_bus),
    .out_ch     (out_bus)
  );

  // Requests waiting to be offered, and results predicted but not yet seen.
  request_t pending_requests[$];
  result_t  awaited_results[$];

  // Shadow copy of the engine state. The store is cleared at reset, which
  // the engine reproduces with its clearing pass.
  logic [7:0]       bitmap_model [BITMAP_BYTES];
  abe_pkg::search_t search_model = abe_pkg::SEARCH_RESET;

  int fail_count   = 0;
  int results_seen = 0;
  int stuck_cycles = 0;

  // Idling controls, set per phase by the sequence below.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit quiet_tail    = 1'b0;

  int src_gap_left    = 0;
  int sink_stall_left = 0;
  int sink_hold_left  = 0;
  int squeezes_done   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int b = 0; b < BITMAP_BYTES; b++) bitmap_model[b] = 8'h00;
  end

  // Applies one request to the shadow bitmap and returns the result the
  // engine must produce for it. Requests are applied in acceptance order,
  // which is also the order in which the engine executes them.
  function automatic result_t bitmap_apply(request_t rq);
    result_t     r;
    int unsigned off;
    int unsigned len;
    int unsigned pos;
    int unsigned nbytes;
    int unsigned limit;
    int unsigned run;
    bit          found;
    r     = '0;
    off   = rq.bit_offset;
    len   = rq.run_length;
    run   = 0;
    found = 1'b0;
    case (rq.mode) inside
      abe_pkg::MODE_SET, abe_pkg::MODE_CLR, abe_pkg::MODE_INV: begin
        // A zero-length run is a no-op; a run crossing the end is refused
        // as a whole and touches nothing.
        if (len != 0) begin
          if (off + len > TOTAL_BITS) begin
            r.status = abe_pkg::ST_RANGE;
          end else begin
            for (pos = off; pos < off + len; pos++) begin
              case (rq.mode)
                abe_pkg::MODE_SET: bitmap_model[pos / 8][pos % 8] = 1'b1;
                abe_pkg::MODE_CLR: bitmap_model[pos / 8][pos % 8] = 1'b0;
                default: bitmap_model[pos / 8][pos % 8] = ~bitmap_model[pos / 8][pos % 8];
              endcase
            end
          end
        end
      end
      abe_pkg::MODE_READ: begin
        if (off >= TOTAL_BITS) r.status = abe_pkg::ST_RANGE;
        else r.read_bit = bitmap_model[off / 8][off % 8];
      end
      abe_pkg::MODE_WRITE: begin
        // The offset is echoed back even when the write is refused.
        r.found_offset = abe_pkg::foff_t'(off);
        if (off >= TOTAL_BITS) r.status = abe_pkg::ST_RANGE;
        else bitmap_model[off / 8][off % 8] = rq.bit_value;
      end
      abe_pkg::MODE_FIND: begin
        // The scan limit saturates at the bitmap size; a missing run reports
        // the limit itself with a not-found status.
        nbytes = search_model;
        if (nbytes > BITMAP_BYTES) nbytes = BITMAP_BYTES;
        limit = nbytes * 8;
        r.found_offset = abe_pkg::foff_t'(limit);
        r.status = abe_pkg::ST_NOT_FOUND;
        if (len != 0) begin
          for (pos = 0; pos < limit && !found; pos++) begin
            if (bitmap_model[pos / 8][pos % 8] == rq.bit_value) begin
              run++;
              if (run == len) begin
                r.found_offset = abe_pkg::foff_t'(pos + 1 - len);
                r.status = abe_pkg::ST_OK;
                found = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Builds one random request. Most start in the scanned part of the bitmap or
  // up to 32 bits past it, with short runs, so finds keep meeting a mixed pattern
  // of set and clear bits; the rest is raw noise and end-of-bitmap boundary cases.
  function automatic request_t compose_request(int unsigned scan_bits);
    request_t    rq;
    int unsigned pick;
    int unsigned span;
    rq.bit_value = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      rq.mode       = abe_pkg::mode_t'($urandom_range(0, 7));
      rq.bit_offset = abe_pkg::offset_t'($urandom);
      rq.run_length = abe_pkg::len_t'($urandom);
      return rq;
    end
    span = scan_bits + 32;
    if (span > TOTAL_BITS) span = TOTAL_BITS;
    if ($urandom_range(0, 99) < 6) begin
      rq.bit_offset = abe_pkg::offset_t'(TOTAL_BITS - 1 - $urandom_range(0, 15));
    end else begin
      rq.bit_offset = abe_pkg::offset_t'($urandom_range(0, span - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 15)      rq.mode = abe_pkg::MODE_SET;
    else if (pick < 30) rq.mode = abe_pkg::MODE_CLR;
    else if (pick < 42) rq.mode = abe_pkg::MODE_INV;
    else if (pick < 55) rq.mode = abe_pkg::MODE_READ;
    else if (pick < 70) rq.mode = abe_pkg::MODE_WRITE;
    else if (pick < 97) rq.mode = abe_pkg::MODE_FIND;
    else if (pick < 99) rq.mode = MODE_SPARE_LO;
    else                rq.mode = MODE_SPARE_HI;
    pick = $urandom_range(0, 99);
    if (pick < 70)      rq.run_length = abe_pkg::len_t'($urandom_range(1, 12));
    else if (pick < 90) rq.run_length = abe_pkg::len_t'($urandom_range(13, 64));
    else if (pick < 95) rq.run_length = '0;
    else                rq.run_length = abe_pkg::len_t'($urandom_range(65, 600));
    return rq;
  endfunction

  task automatic queue_request(input abe_pkg::mode_t m, input int unsigned off,
                               input int unsigned len, input bit v);
    request_t rq;
    rq.mode       = m;
    rq.bit_offset = abe_pkg::offset_t'(off);
    rq.run_length = abe_pkg::len_t'(len);
    rq.bit_value  = v;
    pending_requests.push_back(rq);
  endtask

  // The engine is idle whenever every queued request has been accepted and
  // its result has come back; the limit register is written only then.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || awaited_results.size() != 0);
  endtask

  task automatic write_search_limit(input abe_pkg::search_t value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    // No find can be in flight here, so the shadow copy may change at once.
    search_model = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input abe_pkg::search_t limit, input int count,
                              input int src_pct, input int sink_pct, input bit tail);
    int unsigned scan_bits;
    write_search_limit(limit);
    scan_bits = ((limit > BITMAP_BYTES) ? BITMAP_BYTES : limit) * 8;
    @(negedge clk);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    quiet_tail    = tail;
    repeat (count) pending_requests.push_back(compose_request(scan_bits));
    wait_until_drained();
  endtask

  // Stimulus sequence. New work is queued at the falling edge so the driver
  // never races the sequence for the state of the queue.
  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = abe_pkg::MODE_SET;
    in_bus.bit_offset  = '0;
    in_bus.run_length  = '0;
    in_bus.bit_value   = 1'b0;
    out_bus.ready      = 1'b0;
    src_idle_pct       = 25;
    sink_idle_pct      = 25;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset search limit of 512 bytes. The first two
    // finds confirm that the clearing pass left the whole bitmap at zero.
    @(negedge clk);
    queue_request(abe_pkg::MODE_FIND,  0,    1,    1'b0);
    queue_request(abe_pkg::MODE_FIND,  0,    1,    1'b1);
    // Full-bitmap run, then a find for a run as long as the whole bitmap.
    queue_request(abe_pkg::MODE_SET,   0,    4096, 1'b0);
    queue_request(abe_pkg::MODE_FIND,  0,    4096, 1'b1);
    queue_request(abe_pkg::MODE_READ,  4095, 0,    1'b0);
    // Zero-length run, a run one bit past the end, and all-ones fields.
    queue_request(abe_pkg::MODE_CLR,   10,   0,    1'b1);
    queue_request(abe_pkg::MODE_INV,   4095, 2,    1'b0);
    queue_request(abe_pkg::MODE_SET,   4095, 8191, 1'b1);
    queue_request(abe_pkg::MODE_CLR,   0,    4096, 1'b0);
    queue_request(abe_pkg::MODE_WRITE, 4095, 0,    1'b1);
    queue_request(abe_pkg::MODE_READ,  4095, 0,    1'b0);
    queue_request(abe_pkg::MODE_WRITE, 0,    8191, 1'b0);
    queue_request(abe_pkg::MODE_INV,   3,    13,   1'b0);
    queue_request(abe_pkg::MODE_READ,  7,    0,    1'b1);
    // Zero-length find, and a find longer than everything it can scan.
    queue_request(abe_pkg::MODE_FIND,  0,    0,    1'b1);
    queue_request(abe_pkg::MODE_FIND,  0,    8191, 1'b0);
    queue_request(MODE_SPARE_LO, 4095, 8191, 1'b1);
    queue_request(MODE_SPARE_HI, 4095, 8191, 1'b1);
    wait_until_drained();

    // A zero search limit scans nothing.
    write_search_limit(10'd0);
    @(negedge clk);
    queue_request(abe_pkg::MODE_FIND, 0, 1, 1'b0);
    wait_until_drained();

    // Limits above the bitmap size saturate to the whole bitmap.
    write_search_limit(10'd1023);
    @(negedge clk);
    queue_request(abe_pkg::MODE_FIND, 0, 1,  1'b1);
    queue_request(abe_pkg::MODE_FIND, 0, 14, 1'b1);
    wait_until_drained();

    // The smallest useful limit: one byte, with a run longer than the scan.
    write_search_limit(10'd1);
    @(negedge clk);
    queue_request(abe_pkg::MODE_FIND, 0, 5, 1'b1);
    queue_request(abe_pkg::MODE_FIND, 0, 4, 1'b0);
    queue_request(abe_pkg::MODE_FIND, 0, 9, 1'b1);
    wait_until_drained();

    // Random phases: mostly small scan limits, one saturated one, and a
    // final stretch with both channels running flat out.
    random_phase(10'd4,   140, 30, 30, 1'b0);
    random_phase(10'd16,  140, 0,  0,  1'b0);
    random_phase(10'd1,   140, 50, 10, 1'b0);
    random_phase(10'd64,  140, 10, 50, 1'b0);
    random_phase(10'd600, 145, 20, 20, 1'b0);
    random_phase(10'd2,   145, 0,  0,  1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d predicted results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Request driver. A transaction on offer is held until the engine takes
  // it; between transactions the sender may go quiet for a short burst.
  // While the receiver is in a long stall the sender never idles, so the
  // engine fills up and has to push back on its input.
  always @(posedge clk) begin : request_driver
    request_t taken;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      src_gap_left <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        taken.mode       = in_bus.mode;
        taken.bit_offset = in_bus.bit_offset;
        taken.run_length = in_bus.run_length;
        taken.bit_value  = in_bus.bit_value;
        awaited_results.push_back(bitmap_apply(taken));
        void'(pending_requests.pop_front());
      end
      if (in_bus.valid && !in_bus.ready) begin
        // Still waiting for the engine; leave the transaction as it is.
      end else if (src_gap_left != 0) begin
        src_gap_left <= src_gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (!quiet_tail && sink_hold_left == 0 &&
                   $urandom_range(0, 99) < src_idle_pct) begin
        src_gap_left <= $urandom_range(0, 6);
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid      <= 1'b1;
        in_bus.mode       <= pending_requests[0].mode;
        in_bus.bit_offset <= pending_requests[0].bit_offset;
        in_bus.run_length <= pending_requests[0].run_length;
        in_bus.bit_value  <= pending_requests[0].bit_value;
      end
    end
  end

  // Result receiver. Besides short random stalls it holds ready low for a
  // long stretch twice in the run, once each result count mark is passed.
  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_bus.ready   <= 1'b0;
      sink_stall_left <= 0;
      sink_hold_left  <= 0;
      squeezes_done   <= 0;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
      out_bus.ready  <= 1'b0;
    end else if ((squeezes_done == 0 && results_seen >= SQUEEZE_FIRST) ||
                 (squeezes_done == 1 && results_seen >= SQUEEZE_SECOND)) begin
      sink_hold_left <= HOLD_CYCLES - 1;
      squeezes_done  <= squeezes_done + 1;
      out_bus.ready  <= 1'b0;
    end else if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      out_bus.ready   <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
      sink_stall_left <= $urandom_range(0, 6);
      out_bus.ready   <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result transaction is matched against
  // the oldest prediction.
  always @(posedge clk) begin : result_checker
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.read_bit !== want.read_bit) begin
          $error("read_bit: expected %0d, actual %0d", want.read_bit, out_bus.read_bit);
          fail_count++;
        end
        if (out_bus.found_offset !== want.found_offset) begin
          $error("found_offset: expected %0d, actual %0d",
                 want.found_offset, out_bus.found_offset);
          fail_count++;
        end
        if (out_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_bus.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction or register write counts as
  // progress; a long stretch without one ends the run as a failure.
  always @(posedge clk) begin : progress_watchdog
    if (!rst_n || (in_bus.valid && in_bus.ready) ||
        (out_bus.valid && out_bus.ready) || cfg_wr_en) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
